// File: src/pose_loop_closure_check_defines.svh
// assertion macros used by the loop closure checker
`ifndef POSE_LOOP_CLOSURE_CHECK_DEFINES_SVH
`define POSE_LOOP_CLOSURE_CHECK_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/plc_pkg.sv
// types, constants and tables of the loop closure check
package plc_pkg;

  localparam int POS_WIDTH    = 24;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int COUNT_W      = 16;
  localparam int THR_W        = 23;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = THR_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DIST_THRESHOLD = 1'b0,
    REG_MIN_POSE_COUNT = 1'b1
  } cfg_reg_e;

  localparam logic [COUNT_W-1:0] MIN_POSE_COUNT_RST = COUNT_W'(10);

  // cordic datapath
  localparam int ANGLE_SHIFT   = 32 - ANGLE_WIDTH;
  localparam int XY_W          = 34;
  localparam int Z_W           = 34;
  localparam int HEADING_SHIFT = 17;
  localparam int HV_W          = 16;
  localparam int CORDIC_X0     = 652032874;
  localparam int ATAN_LEN      = 24;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // distance and heading tests
  localparam int DIFF_W = POS_WIDTH + 1;
  localparam int SQ_W   = 2 * POS_WIDTH - 1;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int R2_W   = (2 * POS_WIDTH > THR_SQ_W) ? 2 * POS_WIDTH : THR_SQ_W;
  localparam int HD_W   = ANGLE_WIDTH + 1;

  // bearing test
  localparam int PROD_W  = HV_W + DIFF_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int TAN_W   = 15;
  localparam int TAN_SHIFT = 16;
  localparam int CMP_W   = DOT_W + TAN_SHIFT;
  localparam logic [TAN_W-1:0] TAN20_Q16 = TAN_W'(23853);

  // cordic stages plus the stages that follow them, in cycles
  localparam int LATENCY = CORDIC_STEPS + 5;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     flip;
    logic                     moved;
    logic                     head;
    logic                     near;
  } side_t;

endpackage

// File: src/pose_loop_closure_check.sv
// loop closure check: pipelined cordic heading vector and pose tests
//
// usage: drive the pose fields and raise start_i for one cycle per request;
// busy_o stays low, so a request is taken in every cycle it is offered.
// the result fields come out with done_o high for exactly one cycle,
// once the request has gone through stage 0 and the stages listed next.
// throughput is one request per cycle: one cordic iteration per stage,
// then a stage each for scaling, the four products, the dot and cross
// sums, the tangent product, and the output register.
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 dist_threshold, 1 min_pose_count); write only while no request is
// in flight.
// reset clears the pipeline valid bits and the registers to dist_threshold
// 0 and min_pose_count 10. the receiver has no stall: each result is shown
// once and must be taken in that cycle.
module pose_loop_closure_check import plc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic signed [POS_WIDTH-1:0]   cur_x_i,
  input  logic signed [POS_WIDTH-1:0]   cur_y_i,
  input  logic signed [ANGLE_WIDTH-1:0] cur_heading_i,
  input  logic signed [POS_WIDTH-1:0]   start_x_i,
  input  logic signed [POS_WIDTH-1:0]   start_y_i,
  input  logic signed [ANGLE_WIDTH-1:0] start_heading_i,
  input  logic [COUNT_W-1:0]            pose_count_i,
  output logic                          done_o,
  output logic                          loop_closed_o,
  output logic                          moved_away_o,
  output logic                          start_ahead_o,
  output logic                          near_origin_o,
  output logic                          heading_matches_o
);

  localparam int N = CORDIC_STEPS;
  localparam logic signed [Z_W-1:0]  Z_QUARTER = Z_W'(1) << 30;
  localparam logic signed [Z_W-1:0]  Z_HALF    = Z_W'(1) << 31;
  localparam logic signed [XY_W-1:0] X_INIT    = XY_W'(CORDIC_X0);
  localparam logic [HD_W-1:0]        HEAD_LIM  = HD_W'(1) << (ANGLE_WIDTH - 2);

  // configuration registers
  logic [THR_W-1:0]    dist_threshold_q;
  logic [COUNT_W-1:0]  min_pose_count_q;
  logic [THR_SQ_W-1:0] thr_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_threshold_q <= '0;
      min_pose_count_q <= MIN_POSE_COUNT_RST;
      thr_sq_q         <= '0;
    end else begin
      thr_sq_q <= THR_SQ_W'(dist_threshold_q) * THR_SQ_W'(dist_threshold_q);
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_DIST_THRESHOLD: dist_threshold_q <= cfg_wdata_i[THR_W-1:0];
          REG_MIN_POSE_COUNT: min_pose_count_q <= cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy_o = 1'b0;

  // stage 0: angle fold, differences, squares, count and heading tests
  logic                        accept;
  logic signed [Z_W-1:0]       z_ext;
  logic signed [Z_W-1:0]       z0_d;
  logic signed [HD_W-1:0]      hdiff;
  logic [HD_W-1:0]             hmag;
  logic [POS_WIDTH-1:0]        xmag, ymag;
  side_t                       side0_d;

  logic                        v0_q;
  logic signed [Z_W-1:0]       z0_q;
  side_t                       side0_q;
  logic [SQ_W-1:0]             sq_x_q, sq_y_q;

  assign accept = start_i & ~busy_o;

  always_comb begin
    z_ext = {{(Z_W-32){cur_heading_i[ANGLE_WIDTH-1]}}, cur_heading_i,
             {ANGLE_SHIFT{1'b0}}};
    side0_d      = '0;
    side0_d.flip = 1'b0;
    z0_d         = z_ext;
    if (z_ext > Z_QUARTER) begin
      z0_d         = z_ext - Z_HALF;
      side0_d.flip = 1'b1;
    end else if (z_ext < -Z_QUARTER) begin
      z0_d         = z_ext + Z_HALF;
      side0_d.flip = 1'b1;
    end
    hdiff = HD_W'(start_heading_i) - HD_W'(cur_heading_i);
    hmag  = hdiff[HD_W-1] ? HD_W'(-hdiff) : HD_W'(hdiff);
    side0_d.head  = hmag < HEAD_LIM;
    side0_d.moved = pose_count_i > min_pose_count_q;
    side0_d.dx    = DIFF_W'(start_x_i) - DIFF_W'(cur_x_i);
    side0_d.dy    = DIFF_W'(start_y_i) - DIFF_W'(cur_y_i);
    side0_d.near  = 1'b0;
    xmag = cur_x_i[POS_WIDTH-1] ? POS_WIDTH'(-cur_x_i) : POS_WIDTH'(cur_x_i);
    ymag = cur_y_i[POS_WIDTH-1] ? POS_WIDTH'(-cur_y_i) : POS_WIDTH'(cur_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      z0_q    <= z0_d;
      side0_q <= side0_d;
      sq_x_q  <= SQ_W'(xmag) * SQ_W'(xmag);
      sq_y_q  <= SQ_W'(ymag) * SQ_W'(ymag);
    end
  end

  // cordic stages, one iteration each
  logic                  v_q    [1:N];
  logic signed [XY_W-1:0] x_q   [1:N];
  logic signed [XY_W-1:0] y_q   [1:N];
  logic signed [Z_W-1:0]  z_q   [1:N];
  side_t                  side_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(ATAN_TAB[k]);
    logic                   v_in;
    logic signed [XY_W-1:0] x_in, y_in, x_nx, y_nx;
    logic signed [Z_W-1:0]  z_in, z_nx;
    side_t                  side_in;

    if (k == 0) begin : g_first
      logic [R2_W-1:0] r2;
      assign r2      = R2_W'(sq_x_q) + R2_W'(sq_y_q);
      assign v_in    = v0_q;
      assign x_in    = X_INIT;
      assign y_in    = '0;
      assign z_in    = z0_q;
      always_comb begin
        side_in      = side0_q;
        side_in.near = r2 < R2_W'(thr_sq_q);
      end
    end else begin : g_next
      assign v_in    = v_q[k];
      assign x_in    = x_q[k];
      assign y_in    = y_q[k];
      assign z_in    = z_q[k];
      assign side_in = side_q[k];
    end

    always_comb begin
      if (!z_in[Z_W-1]) begin
        x_nx = x_in - (y_in >>> k);
        y_nx = y_in + (x_in >>> k);
        z_nx = z_in - ATAN_K;
      end else begin
        x_nx = x_in + (y_in >>> k);
        y_nx = y_in - (x_in >>> k);
        z_nx = z_in + ATAN_K;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (v_in) begin
        x_q[k+1]    <= x_nx;
        y_q[k+1]    <= y_nx;
        z_q[k+1]    <= z_nx;
        side_q[k+1] <= side_in;
      end
    end
  end

  // p1: scale and unfold the heading vector
  logic signed [HV_W-1:0] hc_raw, hs_raw;
  logic                   v_p1_q;
  logic signed [HV_W-1:0] hc_q, hs_q;
  side_t                  side_p1_q;

  assign hc_raw = HV_W'(x_q[N] >>> HEADING_SHIFT);
  assign hs_raw = HV_W'(y_q[N] >>> HEADING_SHIFT);

  // p2: products
  logic                     v_p2_q;
  logic signed [PROD_W-1:0] p_cx_q, p_sy_q, p_cy_q, p_sx_q;
  side_t                    side_p2_q;

  // p3: dot and cross
  logic                    v_p3_q;
  logic signed [DOT_W-1:0] dot_q, crs_q;
  side_t                   side_p3_q;

  // p4: tangent compare operands
  logic [DOT_W-1:0] dot_mag, crs_mag;
  logic             v_p4_q;
  logic [CMP_W-1:0] lhs_q, rhs_q;
  logic             dneg_q;
  side_t            side_p4_q;

  assign dot_mag = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
  assign crs_mag = crs_q[DOT_W-1] ? DOT_W'(-crs_q) : DOT_W'(crs_q);

  // output
  logic ahead;
  logic done_q, loop_closed_q, moved_away_q, start_ahead_q, near_origin_q;
  logic heading_matches_q;

  assign ahead = !(dneg_q && (lhs_q <= rhs_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p1_q <= 1'b0;
      v_p2_q <= 1'b0;
      v_p3_q <= 1'b0;
      v_p4_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v_p1_q <= v_q[N];
      v_p2_q <= v_p1_q;
      v_p3_q <= v_p2_q;
      v_p4_q <= v_p3_q;
      done_q <= v_p4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q[N]) begin
      hc_q      <= side_q[N].flip ? -hc_raw : hc_raw;
      hs_q      <= side_q[N].flip ? -hs_raw : hs_raw;
      side_p1_q <= side_q[N];
    end
    if (v_p1_q) begin
      p_cx_q    <= PROD_W'(hc_q) * PROD_W'($signed(side_p1_q.dx));
      p_sy_q    <= PROD_W'(hs_q) * PROD_W'($signed(side_p1_q.dy));
      p_cy_q    <= PROD_W'(hc_q) * PROD_W'($signed(side_p1_q.dy));
      p_sx_q    <= PROD_W'(hs_q) * PROD_W'($signed(side_p1_q.dx));
      side_p2_q <= side_p1_q;
    end
    if (v_p2_q) begin
      dot_q     <= DOT_W'(p_cx_q) + DOT_W'(p_sy_q);
      crs_q     <= DOT_W'(p_cy_q) - DOT_W'(p_sx_q);
      side_p3_q <= side_p2_q;
    end
    if (v_p3_q) begin
      lhs_q     <= {crs_mag, {TAN_SHIFT{1'b0}}};
      rhs_q     <= CMP_W'(dot_mag) * CMP_W'(TAN20_Q16);
      dneg_q    <= dot_q[DOT_W-1];
      side_p4_q <= side_p3_q;
    end
    if (v_p4_q) begin
      loop_closed_q     <= side_p4_q.moved & side_p4_q.near & side_p4_q.head & ahead;
      moved_away_q      <= side_p4_q.moved;
      start_ahead_q     <= ahead;
      near_origin_q     <= side_p4_q.near;
      heading_matches_q <= side_p4_q.head;
    end
  end

  assign done_o            = done_q;
  assign loop_closed_o     = loop_closed_q;
  assign moved_away_o      = moved_away_q;
  assign start_ahead_o     = start_ahead_q;
  assign near_origin_o     = near_origin_q;
  assign heading_matches_o = heading_matches_q;

endmodule

// File: src/plc_checker.sv
// port-level checks of the loop closure check, bound to the top level
`include "pose_loop_closure_check_defines.svh"

module plc_checker import plc_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          cfg_we_i,
  input logic [CFG_ADDR_W-1:0]         cfg_addr_i,
  input logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input logic signed [POS_WIDTH-1:0]   cur_x_i,
  input logic signed [POS_WIDTH-1:0]   cur_y_i,
  input logic signed [ANGLE_WIDTH-1:0] cur_heading_i,
  input logic signed [POS_WIDTH-1:0]   start_x_i,
  input logic signed [POS_WIDTH-1:0]   start_y_i,
  input logic signed [ANGLE_WIDTH-1:0] start_heading_i,
  input logic [COUNT_W-1:0]            pose_count_i,
  input logic                          done_o,
  input logic                          loop_closed_o,
  input logic                          moved_away_o,
  input logic                          start_ahead_o,
  input logic                          near_origin_o,
  input logic                          heading_matches_o
);

  localparam int LAG   = LATENCY + 1;
  localparam int CNT_W = $clog2(LAG + 2);
  localparam logic [HD_W-1:0] HEAD_LIM = HD_W'(1) << (ANGLE_WIDTH - 2);

  logic             acc;
  logic [CNT_W-1:0] cnt_q;
  logic signed [HD_W-1:0] hdiff;
  logic [HD_W-1:0]  hmag;
  logic             head_ref;
  logic             warm;

  assign acc      = start_i & ~busy_o;
  assign hdiff    = HD_W'(start_heading_i) - HD_W'(cur_heading_i);
  assign hmag     = hdiff[HD_W-1] ? HD_W'(-hdiff) : HD_W'(hdiff);
  assign head_ref = hmag < HEAD_LIM;
  assign warm     = cnt_q > CNT_W'(LAG);

  // cycles since reset, saturating past the latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (!warm) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  `PLC_ASSERT_IMP(a_request_gives_result, clk_i, rst_ni, warm && $past(acc, LAG), done_o, "request without result")
  `PLC_ASSERT_NEXT(a_no_spurious_result, clk_i, rst_ni, (cnt_q >= CNT_W'(LAG)) && !$past(acc, LAG - 1), !done_o, "result without request")
  `PLC_ASSERT_IMP(a_closed_is_and, clk_i, rst_ni, done_o, loop_closed_o == (moved_away_o && start_ahead_o && near_origin_o && heading_matches_o), "loop_closed disagrees with tests")
  `PLC_ASSERT_IMP(a_heading_test, clk_i, rst_ni, warm && done_o, heading_matches_o == $past(head_ref, LAG), "heading test mismatch")

endmodule

bind pose_loop_closure_check plc_checker u_plc_checker (.*);

// File: tb/sv/pose_loop_closure_check_test.sv
// self-checking testbench for the loop closure check: directed table, random poses, predictor
`timescale 1ns / 100ps

module pose_loop_closure_check_test;
  import plc_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 80;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0]   cur_x;
    logic signed [POS_WIDTH-1:0]   cur_y;
    logic signed [ANGLE_WIDTH-1:0] cur_heading;
    logic signed [POS_WIDTH-1:0]   start_x;
    logic signed [POS_WIDTH-1:0]   start_y;
    logic signed [ANGLE_WIDTH-1:0] start_heading;
    logic [COUNT_W-1:0]            pose_count;
  } pose_req_t;

  typedef struct packed {
    logic loop_closed;
    logic moved_away;
    logic start_ahead;
    logic near_origin;
    logic heading_matches;
  } closure_flags_t;

  typedef struct packed {
    pose_req_t      req;
    logic           typed;
    closure_flags_t flags;
  } pose_row_t;

  // rows run with the reset settings: threshold 0, minimum count 10
  localparam int DIR_LEN = 23;
  localparam pose_row_t DIR_TAB [DIR_LEN] = '{
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd0, 24'sd0, 16'sd0, 16'd0}, 1'b1, 5'b00101},
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd0, 24'sd0, 16'sd0, 16'd10}, 1'b1, 5'b00101},
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd0, 24'sd0, 16'sd0, 16'd11}, 1'b1, 5'b01101},
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd1000, 24'sd0, 16'sd0, 16'hffff}, 1'b1, 5'b01101},
    '{'{24'sd0, 24'sd0, 16'sd0, -24'sd1000, 24'sd0, 16'sd0, 16'hffff}, 1'b1, 5'b01001},
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd0, 24'sd0, 16'sd16383, 16'd0}, 1'b1, 5'b00101},
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd0, 24'sd0, 16'sd16384, 16'd0}, 1'b1, 5'b00100},
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd0, 24'sd0, -16'sd16383, 16'd0}, 1'b1, 5'b00101},
    '{'{24'sd0, 24'sd0, 16'sd0, 24'sd0, 24'sd0, -16'sd16384, 16'd0}, 1'b1, 5'b00100},
    '{'{24'sd0, 24'sd0, 16'sh8000, 24'sd0, 24'sd0, 16'sh7fff, 16'd0}, 1'b1, 5'b00100},
    '{'{24'sd0, 24'sd0, 16'sh8000, 24'sd0, 24'sd0, 16'sh8000, 16'd0}, 1'b1, 5'b00101},
    '{'{24'sh800000, 24'sh800000, 16'sd8192, 24'sh7fffff, 24'sh7fffff, 16'sd8192, 16'd11},
      1'b1, 5'b01101},
    '{'{24'sh7fffff, 24'sh7fffff, 16'sd8192, 24'sh800000, 24'sh800000, 16'sd8192, 16'd11},
      1'b0, 5'b00000},
    '{'{24'sd0, 24'sd0, 16'sd16384, 24'sd0, 24'sd1000, 16'sd16384, 16'd20}, 1'b0, 5'b00000},
    '{'{24'sd0, 24'sd0, -16'sd16384, 24'sd0, 24'sd1000, -16'sd16384, 16'd20}, 1'b0, 5'b00000},
    '{'{24'sd0, 24'sd0, 16'sd16385, -24'sd1000, 24'sd0, 16'sd0, 16'd9}, 1'b0, 5'b00000},
    '{'{24'sd0, 24'sd0, -16'sd16385, 24'sd1000, 24'sd0, 16'sd0, 16'd9}, 1'b0, 5'b00000},
    '{'{24'sd0, 24'sd0, 16'sd0, -24'sd9397, 24'sd3420, 16'sd100, 16'd50}, 1'b0, 5'b00000},
    '{'{24'sd0, 24'sd0, 16'sd0, -24'sd9397, 24'sd3410, 16'sd100, 16'd50}, 1'b0, 5'b00000},
    '{'{24'sd0, 24'sd0, 16'sd0, -24'sd9397, -24'sd3450, -16'sd100, 16'd50}, 1'b0, 5'b00000},
    '{'{24'sh7fffff, 24'sd0, 16'sh7fff, 24'sd0, 24'sd0, 16'sh7fff, 16'd12}, 1'b0, 5'b00000},
    '{'{-24'sd5, 24'sd7, 16'sd21845, 24'sd300, -24'sd200, 16'sd20000, 16'd0}, 1'b0, 5'b00000},
    '{'{24'sh7fffff, 24'sh7fffff, 16'sh7fff, 24'sh7fffff, 24'sh7fffff, 16'sh7fff, 16'hffff},
      1'b1, 5'b01101}
  };

  localparam int PH_THR  [NUM_PHASES] = '{2048, 8388607, 0, 300000, 1, 40000};
  localparam int PH_MIN  [NUM_PHASES] = '{10, 0, 65535, 1000, 65534, 3};
  localparam int PH_IDLE [NUM_PHASES] = '{0, 62, 24, 62, 0, 24};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic                          cfg_we_i;
  logic [CFG_ADDR_W-1:0]         cfg_addr_i;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i;
  logic signed [POS_WIDTH-1:0]   cur_x_i;
  logic signed [POS_WIDTH-1:0]   cur_y_i;
  logic signed [ANGLE_WIDTH-1:0] cur_heading_i;
  logic signed [POS_WIDTH-1:0]   start_x_i;
  logic signed [POS_WIDTH-1:0]   start_y_i;
  logic signed [ANGLE_WIDTH-1:0] start_heading_i;
  logic [COUNT_W-1:0]            pose_count_i;
  logic                          done_o;
  logic                          loop_closed_o;
  logic                          moved_away_o;
  logic                          start_ahead_o;
  logic                          near_origin_o;
  logic                          heading_matches_o;

  logic [THR_W-1:0]   thr_cfg;
  logic [COUNT_W-1:0] min_count_cfg;
  closure_flags_t     closure_q [$];
  closure_flags_t     want_flags;
  int                 mismatch_count;
  int                 result_count;
  int                 cycle_count;

  pose_loop_closure_check dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cur_x_i          (cur_x_i),
    .cur_y_i          (cur_y_i),
    .cur_heading_i    (cur_heading_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .start_heading_i  (start_heading_i),
    .pose_count_i     (pose_count_i),
    .done_o           (done_o),
    .loop_closed_o    (loop_closed_o),
    .moved_away_o     (moved_away_o),
    .start_ahead_o    (start_ahead_o),
    .near_origin_o    (near_origin_o),
    .heading_matches_o(heading_matches_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // rotation-mode cordic giving the heading direction, about q13
  function automatic void heading_cordic(input longint ang, output longint c,
                                         output longint s);
    longint z;
    longint x;
    longint y;
    longint nx;
    longint atan;
    bit     flip;
    z = ang * (64'sd1 <<< ANGLE_SHIFT);
    x = CORDIC_X0;
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z = z - (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z = z + (64'sd1 <<< 31);
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      atan = longint'({32'b0, ATAN_TAB[i]});
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan;
      end
      x = nx;
    end
    c = x >>> HEADING_SHIFT;
    s = y >>> HEADING_SHIFT;
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic closure_flags_t predict_closure(pose_req_t r);
    longint cx;
    longint cy;
    longint sx;
    longint sy;
    longint thr;
    longint hc;
    longint hs;
    longint dot;
    longint crs;
    closure_flags_t f;
    cx = r.cur_x;
    cy = r.cur_y;
    sx = r.start_x;
    sy = r.start_y;
    thr = longint'({41'b0, thr_cfg});
    f.moved_away = r.pose_count > min_count_cfg;
    f.near_origin = (cx * cx + cy * cy) < (thr * thr);
    f.heading_matches = abs64(longint'(r.start_heading) - longint'(r.cur_heading))
                        < (64'sd1 <<< (ANGLE_WIDTH - 2));
    heading_cordic(longint'(r.cur_heading), hc, hs);
    dot = hc * (sx - cx) + hs * (sy - cy);
    crs = hc * (sy - cy) - hs * (sx - cx);
    f.start_ahead = (dot >= 0) ||
                    ((abs64(crs) <<< 16) > longint'({49'b0, TAN20_Q16}) * abs64(dot));
    f.loop_closed = f.moved_away && f.near_origin && f.heading_matches && f.start_ahead;
    return f;
  endfunction

  task automatic report_mismatch(string what);
    $display("result %0d: %s", result_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (closure_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want_flags = closure_q.pop_front();
        if (loop_closed_o !== want_flags.loop_closed)
          report_mismatch($sformatf("loop_closed got %b want %b",
                                    loop_closed_o, want_flags.loop_closed));
        if (moved_away_o !== want_flags.moved_away)
          report_mismatch($sformatf("moved_away got %b want %b",
                                    moved_away_o, want_flags.moved_away));
        if (start_ahead_o !== want_flags.start_ahead)
          report_mismatch($sformatf("start_ahead got %b want %b",
                                    start_ahead_o, want_flags.start_ahead));
        if (near_origin_o !== want_flags.near_origin)
          report_mismatch($sformatf("near_origin got %b want %b",
                                    near_origin_o, want_flags.near_origin));
        if (heading_matches_o !== want_flags.heading_matches)
          report_mismatch($sformatf("heading_matches got %b want %b",
                                    heading_matches_o, want_flags.heading_matches));
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input pose_req_t r, input logic typed,
                              input closure_flags_t flags);
    closure_flags_t expd;
    expd = typed ? flags : predict_closure(r);
    @(negedge clk_i);
    start_i         <= 1'b1;
    cur_x_i         <= r.cur_x;
    cur_y_i         <= r.cur_y;
    cur_heading_i   <= r.cur_heading;
    start_x_i       <= r.start_x;
    start_y_i       <= r.start_y;
    start_heading_i <= r.start_heading;
    pose_count_i    <= r.pose_count;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    closure_q.push_back(expd);
  endtask

  task automatic settle_pipeline();
    while (closure_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic program_settings(input int thr, input int min_count);
    settle_pipeline();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_DIST_THRESHOLD;
    cfg_wdata_i <= THR_W'(thr);
    @(negedge clk_i);
    cfg_addr_i  <= REG_MIN_POSE_COUNT;
    cfg_wdata_i <= {7'($urandom), COUNT_W'(min_count)};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_cfg = THR_W'(thr);
    min_count_cfg = COUNT_W'(min_count);
  endtask

  // mostly poses near a closure, the rest fully random
  task automatic make_random_pose(output pose_req_t r);
    int lim;
    int span;
    int cnt;
    if ($urandom_range(99) < 35) begin
      r.cur_x         = POS_WIDTH'($urandom);
      r.cur_y         = POS_WIDTH'($urandom);
      r.cur_heading   = ANGLE_WIDTH'($urandom);
      r.start_x       = POS_WIDTH'($urandom);
      r.start_y       = POS_WIDTH'($urandom);
      r.start_heading = ANGLE_WIDTH'($urandom);
      r.pose_count    = COUNT_W'($urandom);
    end else begin
      lim  = int'(thr_cfg >> 1) + 1;
      span = $urandom_range(1) ? 4095 : 1048575;
      r.cur_x         = POS_WIDTH'(int'($urandom_range(2 * lim)) - lim);
      r.cur_y         = POS_WIDTH'(int'($urandom_range(2 * lim)) - lim);
      r.cur_heading   = ANGLE_WIDTH'($urandom);
      r.start_heading = ANGLE_WIDTH'(int'(r.cur_heading) + int'($urandom_range(40000)) - 20000);
      r.start_x       = POS_WIDTH'(int'(r.cur_x) + int'($urandom_range(2 * span)) - span);
      r.start_y       = POS_WIDTH'(int'(r.cur_y) + int'($urandom_range(2 * span)) - span);
      cnt = int'(min_count_cfg) + int'($urandom_range(40)) - 8;
      if (cnt < 0) cnt = 0;
      if (cnt > 65535) cnt = 65535;
      r.pose_count = COUNT_W'(cnt);
    end
  endtask

  initial begin
    pose_req_t r;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = REG_DIST_THRESHOLD;
    cfg_wdata_i     = '0;
    cur_x_i         = '0;
    cur_y_i         = '0;
    cur_heading_i   = '0;
    start_x_i       = '0;
    start_y_i       = '0;
    start_heading_i = '0;
    pose_count_i    = '0;
    thr_cfg         = '0;
    min_count_cfg   = MIN_POSE_COUNT_RST;
    mismatch_count  = 0;
    result_count    = 0;
    cycle_count     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_LEN; i++)
      send_request(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].flags);
    @(negedge clk_i);
    start_i <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_settings(PH_THR[p], PH_MIN[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while ($urandom_range(99) < PH_IDLE[p]) begin
          @(negedge clk_i);
          start_i <= 1'b0;
        end
        make_random_pose(r);
        send_request(r, 1'b0, '0);
      end
      @(negedge clk_i);
      start_i <= 1'b0;
    end

    settle_pipeline();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
